FILE: rtl/core/tlfo_pkg.sv
package tlfo_pkg;

    localparam int OUT_FIELDS       = 7;
    localparam int NUM_CHANNELS_DEF = 7;
    localparam int CH_X_W           = 4;

    localparam int CV_W      = 17;
    localparam int GAIN_W    = 16;
    localparam int BASE_W    = 23;
    localparam int SCALE_W   = 37;
    localparam int MULT_W    = 15;
    localparam int MULTS_W   = 45;
    localparam int LVL_W     = 17;
    localparam int PHASE_W   = 33;
    localparam int PROD_W    = 33;
    localparam int DELTA_W   = 26;
    localparam int RM_W      = 38;
    localparam int ACC_W     = 75;
    localparam int SCALE_LO  = 19;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 45;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_RATE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CV_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIPOLAR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MULTS_FIRST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MULTS_NEXT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_LAST    = 3'd6;

    localparam logic [BASE_W-1:0]  RST_BASE_RATE  = 23'd65536;
    localparam logic [SCALE_W-1:0] RST_STEP_SCALE = 37'd11728124030;
    localparam logic [MULT_W-1:0]  RST_MULT       = 15'd1024;

    localparam logic signed [26:0] RATE_MIN = 27'sd655;
    localparam logic signed [26:0] RATE_MAX = 27'sd6553600;

    localparam logic signed [34:0] UNIT_PHASE   = 35'sd4294967296;
    localparam logic signed [34:0] DOUBLE_PHASE = 35'sd8589934592;
    localparam logic [PHASE_W-1:0] UNIT_STEP    = 33'h1_0000_0000;
    localparam logic [48:0]        LVL_ROUND    = 49'd2147483648;
    localparam logic [LVL_W-1:0]   BIPOLAR_OFFSET = 17'd20480;

    typedef struct packed {
        logic take_in;
        logic scale;
        logic rate;
        logic mulr;
        logic mul0;
        logic mul1;
        logic upd;
        logic lvl;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic last_ch;
    } t_dp_sts;

endpackage

FILE: rtl/core/tlfo_dp.sv
module tlfo_dp #(
    parameter int NUM_CHANNELS = tlfo_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [tlfo_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tlfo_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic signed [tlfo_pkg::CV_W-1:0]      i_rate_cv,
    input  tlfo_pkg::t_dp_cmd                     i_cmd,
    output tlfo_pkg::t_dp_sts                     o_sts,
    output logic signed [tlfo_pkg::LVL_W-1:0]     o_level [tlfo_pkg::OUT_FIELDS]
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [tlfo_pkg::BASE_W-1:0]         r_base;
    logic signed [tlfo_pkg::GAIN_W-1:0]  r_gain;
    logic [tlfo_pkg::SCALE_W-1:0]        r_scale;
    logic                                r_bipolar;
    logic [tlfo_pkg::MULTS_W-1:0]        r_mults_a;
    logic [tlfo_pkg::MULTS_W-1:0]        r_mults_b;
    logic [tlfo_pkg::MULT_W-1:0]         r_mult_last;

    logic signed [tlfo_pkg::PROD_W-1:0]  r_prod;
    logic signed [tlfo_pkg::DELTA_W-1:0] r_delta;
    logic [tlfo_pkg::BASE_W-1:0]         r_rate;
    logic [tlfo_pkg::RM_W-1:0]           r_rm;
    logic [tlfo_pkg::ACC_W-1:0]          r_acc;
    logic [CH_W-1:0]                     r_ch;

    logic [tlfo_pkg::PHASE_W-1:0]        r_phase [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]             r_fall;

    logic [tlfo_pkg::LVL_W-1:0]          r_buf [tlfo_pkg::OUT_FIELDS];
    logic [tlfo_pkg::LVL_W-1:0]          r_out [tlfo_pkg::OUT_FIELDS];

    logic signed [36:0]                  s_pe;
    logic signed [36:0]                  s_rnd;
    logic signed [26:0]                  s_rsum;
    logic [tlfo_pkg::BASE_W-1:0]         s_rate;
    logic [tlfo_pkg::CH_X_W-1:0]         s_ch_x;
    logic [tlfo_pkg::MULT_W-1:0]         s_mult;
    logic [tlfo_pkg::SCALE_LO-1:0]       s_mb;
    logic [56:0]                         s_pp;
    logic [tlfo_pkg::PHASE_W-1:0]        s_step;
    logic [tlfo_pkg::PHASE_W-1:0]        s_ph;
    logic signed [34:0]                  s_sum;
    logic signed [34:0]                  s_fold;
    logic                                s_fall;
    logic [48:0]                         s_scaled;
    logic [tlfo_pkg::LVL_W-1:0]          s_lvl;

    always_comb begin
        s_pe  = 37'(r_prod);
        s_rnd = (s_pe <<< 3) + (s_pe <<< 1) + 37'sd1024;
    end

    always_comb begin
        s_rsum = $signed({4'b0, r_base}) + $signed({r_delta[tlfo_pkg::DELTA_W-1], r_delta});
        if (s_rsum > tlfo_pkg::RATE_MAX) begin
            s_rate = tlfo_pkg::RATE_MAX[tlfo_pkg::BASE_W-1:0];
        end else if (s_rsum < tlfo_pkg::RATE_MIN) begin
            s_rate = tlfo_pkg::RATE_MIN[tlfo_pkg::BASE_W-1:0];
        end else begin
            s_rate = s_rsum[tlfo_pkg::BASE_W-1:0];
        end
    end

    always_comb begin
        s_ch_x = tlfo_pkg::CH_X_W'(r_ch);
        case (s_ch_x)
            4'd0:    s_mult = r_mults_a[14:0];
            4'd1:    s_mult = r_mults_a[29:15];
            4'd2:    s_mult = r_mults_a[44:30];
            4'd3:    s_mult = r_mults_b[14:0];
            4'd4:    s_mult = r_mults_b[29:15];
            4'd5:    s_mult = r_mults_b[44:30];
            default: s_mult = r_mult_last;
        endcase
    end

    always_comb begin
        s_mb = i_cmd.mul1 ? {1'b0, r_scale[tlfo_pkg::SCALE_W-1:tlfo_pkg::SCALE_LO]}
                          : r_scale[tlfo_pkg::SCALE_LO-1:0];
        s_pp = r_rm * s_mb;
    end

    always_comb begin
        s_step = r_acc[74] ? tlfo_pkg::UNIT_STEP : {1'b0, r_acc[73:42]};
        s_ph   = r_phase[r_ch];
        if (r_fall[r_ch]) begin
            s_sum = $signed({2'b0, s_ph}) - $signed({2'b0, s_step});
        end else begin
            s_sum = $signed({2'b0, s_ph}) + $signed({2'b0, s_step});
        end
        s_fall = r_fall[r_ch];
        s_fold = s_sum;
        if (s_sum > tlfo_pkg::UNIT_PHASE) begin
            s_fall = 1'b1;
            s_fold = tlfo_pkg::DOUBLE_PHASE - s_sum;
        end else if (s_sum < 35'sd0) begin
            s_fall = 1'b0;
            s_fold = -s_sum;
        end
    end

    always_comb begin
        s_scaled = ({16'b0, s_ph} << 15) + ({16'b0, s_ph} << 13) + tlfo_pkg::LVL_ROUND;
        s_lvl    = r_bipolar ? s_scaled[48:32] - tlfo_pkg::BIPOLAR_OFFSET : s_scaled[48:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= tlfo_pkg::RST_BASE_RATE;
            r_gain      <= '0;
            r_scale     <= tlfo_pkg::RST_STEP_SCALE;
            r_bipolar   <= 1'b0;
            r_mults_a   <= {3{tlfo_pkg::RST_MULT}};
            r_mults_b   <= {3{tlfo_pkg::RST_MULT}};
            r_mult_last <= tlfo_pkg::RST_MULT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tlfo_pkg::REG_BASE_RATE:   r_base      <= i_cfg_data[tlfo_pkg::BASE_W-1:0];
                tlfo_pkg::REG_CV_GAIN:     r_gain      <= i_cfg_data[tlfo_pkg::GAIN_W-1:0];
                tlfo_pkg::REG_STEP_SCALE:  r_scale     <= i_cfg_data[tlfo_pkg::SCALE_W-1:0];
                tlfo_pkg::REG_BIPOLAR:     r_bipolar   <= i_cfg_data[0];
                tlfo_pkg::REG_MULTS_FIRST: r_mults_a   <= i_cfg_data;
                tlfo_pkg::REG_MULTS_NEXT:  r_mults_b   <= i_cfg_data;
                tlfo_pkg::REG_MULT_LAST:   r_mult_last <= i_cfg_data[tlfo_pkg::MULT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_prod <= i_rate_cv * r_gain;
        end
        if (i_cmd.scale) begin
            r_delta <= s_rnd[36:11];
        end
        if (i_cmd.rate) begin
            r_rate <= s_rate;
        end
        if (i_cmd.mulr) begin
            r_rm <= r_rate * s_mult;
        end
        if (i_cmd.mul0) begin
            r_acc <= {18'b0, s_pp};
        end
        if (i_cmd.mul1) begin
            r_acc <= r_acc + {s_pp[55:0], 19'b0};
        end
        if (i_cmd.lvl && (s_ch_x < tlfo_pkg::CH_X_W'(tlfo_pkg::OUT_FIELDS))) begin
            r_buf[s_ch_x[2:0]] <= s_lvl;
        end
        if (i_cmd.publish) begin
            r_out <= r_buf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch   <= '0;
            r_fall <= '0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_phase[k] <= '0;
            end
        end else begin
            if (i_cmd.rate) begin
                r_ch <= '0;
            end else if (i_cmd.lvl) begin
                r_ch <= r_ch + CH_W'(1);
            end
            if (i_cmd.upd) begin
                r_phase[r_ch] <= s_fold[tlfo_pkg::PHASE_W-1:0];
                r_fall[r_ch]  <= s_fall;
            end
        end
    end

    assign o_sts.last_ch = (r_ch == CH_W'(NUM_CHANNELS - 1));

    always_comb begin
        for (int k = 0; k < tlfo_pkg::OUT_FIELDS; k++) begin
            o_level[k] = (k < NUM_CHANNELS) ? r_out[k] : '0;
        end
    end

endmodule

FILE: rtl/core/tlfo_ctrl.sv
module tlfo_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  tlfo_pkg::t_dp_sts i_sts,
    output tlfo_pkg::t_dp_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCALE = 4'd1;
    localparam logic [3:0] S_RATE  = 4'd2;
    localparam logic [3:0] S_MULR  = 4'd3;
    localparam logic [3:0] S_MUL0  = 4'd4;
    localparam logic [3:0] S_MUL1  = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_LVL   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_RATE;
            end
            S_RATE: begin
                o_cmd.rate = 1'b1;
                n_state    = S_MULR;
            end
            S_MULR: begin
                o_cmd.mulr = 1'b1;
                n_state    = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul0 = 1'b1;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_LVL;
            end
            S_LVL: begin
                o_cmd.lvl = 1'b1;
                n_state   = i_sts.last_ch ? S_DONE : S_MULR;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_SCALE))
        else $error("accepted word did not start the rate pass");

    a_loop_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LVL && !i_sts.last_ch) |=> (r_state == S_MULR))
        else $error("channel loop ended early");

    a_publish_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

    a_publish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |=> r_out_valid)
        else $error("published result not presented");

endmodule

FILE: rtl/core/triangle_lfo_bank_ratio.sv
// Bank of triangle LFOs on one master rate. Each accepted rate_cv word forms the
// clamped master rate, then walks the channels one after another through shared
// multipliers (rate times channel multiplier, then two partial products against
// step_scale on one multiplier), a phase update with fold, and a level computation.
// The result is presented once the word has passed the scale and rate states, the
// channel loop (MULR, MUL0, MUL1, UPD and LVL for each channel) and the done state,
// and no new word is taken before the bank is back in idle with its result published.
// The input stalls until the result has moved to the output register, so the next
// word is taken while a finished result still waits downstream. Configuration
// writes are always ready and must arrive only while the bank is idle.
module triangle_lfo_bank_ratio #(
    parameter int NUM_CHANNELS = tlfo_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tlfo_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tlfo_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [tlfo_pkg::CV_W-1:0]    i_rate_cv,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tlfo_pkg::LVL_W-1:0]   o_level_0,
    output logic signed [tlfo_pkg::LVL_W-1:0]   o_level_1,
    output logic signed [tlfo_pkg::LVL_W-1:0]   o_level_2,
    output logic signed [tlfo_pkg::LVL_W-1:0]   o_level_3,
    output logic signed [tlfo_pkg::LVL_W-1:0]   o_level_4,
    output logic signed [tlfo_pkg::LVL_W-1:0]   o_level_5,
    output logic signed [tlfo_pkg::LVL_W-1:0]   o_level_6
);

    tlfo_pkg::t_dp_cmd                   cmd;
    tlfo_pkg::t_dp_sts                   sts;
    logic signed [tlfo_pkg::LVL_W-1:0]   level [tlfo_pkg::OUT_FIELDS];

    assign o_cfg_ready = 1'b1;

    tlfo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tlfo_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rate_cv   (i_rate_cv),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_level     (level)
    );

    assign o_level_0 = level[0];
    assign o_level_1 = level[1];
    assign o_level_2 = level[2];
    assign o_level_3 = level[3];
    assign o_level_4 = level[4];
    assign o_level_5 = level[5];
    assign o_level_6 = level[6];

endmodule

FILE: tb/tlfo_bank_track_pkg.sv
`timescale 1ns / 1ps
package tlfo_bank_track_pkg;
    import tlfo_pkg::*;

    typedef logic [OUT_FIELDS-1:0][LVL_W-1:0] t_levels;

    class lfo_bank_tracker;
        logic [BASE_W-1:0]         base_rate;
        logic signed [GAIN_W-1:0]  cv_gain;
        logic [SCALE_W-1:0]        step_scale;
        logic                      bipolar;
        logic [MULTS_W-1:0]        mults_first;
        logic [MULTS_W-1:0]        mults_next;
        logic [MULT_W-1:0]         mult_last;
        longint                    phase [NUM_CHANNELS_DEF];
        bit                        falling [NUM_CHANNELS_DEF];
        t_levels                   pending_levels [$];
        int words;
        int checked;
        int mismatches;
        int saturated;
        int top_folds;
        int bottom_folds;
        int clamped;

        function new();
            base_rate   = RST_BASE_RATE;
            cv_gain     = '0;
            step_scale  = RST_STEP_SCALE;
            bipolar     = 1'b0;
            mults_first = {3{RST_MULT}};
            mults_next  = {3{RST_MULT}};
            mult_last   = RST_MULT;
            foreach (phase[i]) begin
                phase[i]   = 0;
                falling[i] = 1'b0;
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BASE_RATE:   base_rate   = data[BASE_W-1:0];
                REG_CV_GAIN:     cv_gain     = data[GAIN_W-1:0];
                REG_STEP_SCALE:  step_scale  = data[SCALE_W-1:0];
                REG_BIPOLAR:     bipolar     = data[0];
                REG_MULTS_FIRST: mults_first = data[MULTS_W-1:0];
                REG_MULTS_NEXT:  mults_next  = data[MULTS_W-1:0];
                REG_MULT_LAST:   mult_last   = data[MULT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [MULT_W-1:0] chan_mult(int ch);
            if (ch < 3)
                return mults_first[MULT_W*ch +: MULT_W];
            if (ch < 6)
                return mults_next[MULT_W*(ch-3) +: MULT_W];
            return mult_last;
        endfunction

        function void note_rate_word(logic signed [CV_W-1:0] cv);
            longint prod;
            longint rate;
            longint step;
            longint p;
            longint lvl;
            logic [ACC_W-1:0] acc;
            logic [ACC_W-1:0] stepw;
            t_levels lv;
            prod = longint'(cv) * longint'(cv_gain) * 10;
            rate = longint'(base_rate) + ((prod + 1024) >>> 11);
            if (rate > RATE_MAX) begin
                rate = RATE_MAX;
                clamped++;
            end else if (rate < RATE_MIN) begin
                rate = RATE_MIN;
                clamped++;
            end
            lv = '0;
            for (int ch = 0; ch < NUM_CHANNELS_DEF; ch++) begin
                acc = ACC_W'(rate) * ACC_W'(chan_mult(ch)) * ACC_W'(step_scale);
                stepw = acc >> 42;
                if (stepw > ACC_W'(UNIT_STEP)) begin
                    stepw = ACC_W'(UNIT_STEP);
                    saturated++;
                end
                step = longint'(stepw[PHASE_W-1:0]);
                p = falling[ch] ? phase[ch] - step : phase[ch] + step;
                if (p > longint'(UNIT_PHASE)) begin
                    falling[ch] = 1'b1;
                    p = longint'(DOUBLE_PHASE) - p;
                    top_folds++;
                end else if (p < 0) begin
                    falling[ch] = 1'b0;
                    p = -p;
                    bottom_folds++;
                end
                phase[ch] = p;
                lvl = (p * 40960 + 64'sd2147483648) >>> 32;
                if (bipolar)
                    lvl = lvl - longint'(BIPOLAR_OFFSET);
                if (ch < OUT_FIELDS)
                    lv[ch] = lvl[LVL_W-1:0];
            end
            pending_levels.push_back(lv);
            words++;
        endfunction

        function void check_levels(t_levels got);
            t_levels want;
            checked++;
            if (pending_levels.size() == 0) begin
                mismatches++;
                if (mismatches <= 50)
                    $display("%0t: result with no word pending, expected none, got level_0 %0d",
                             $time, $signed(got[0]));
                return;
            end
            want = pending_levels.pop_front();
            for (int f = 0; f < OUT_FIELDS; f++) begin
                if (got[f] !== want[f]) begin
                    mismatches++;
                    if (mismatches <= 50)
                        $display("%0t: level_%0d expected %0d got %0d",
                                 $time, f, $signed(want[f]), $signed(got[f]));
                end
            end
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction
    endclass

endpackage

FILE: tb/triangle_lfo_bank_ratio_tb.sv
`timescale 1ns / 1ps
module triangle_lfo_bank_ratio_tb;
    import tlfo_pkg::*;
    import tlfo_bank_track_pkg::*;

    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 45;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 135;
    localparam int HOLD_CYCLES   = 400;

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_style;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data  = '0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    logic signed [CV_W-1:0]   i_rate_cv   = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [LVL_W-1:0]  o_level_0, o_level_1, o_level_2, o_level_3;
    logic signed [LVL_W-1:0]  o_level_4, o_level_5, o_level_6;
    t_levels                  out_levels;

    lfo_bank_tracker bank_track = new();

    int        burst_left;
    int        settings_used;
    int        rx_cycle;
    int        hold_left;
    int        idle_cycles;
    bit        hold_done;
    t_rx_style rx_style = RX_FREE;

    assign out_levels = {o_level_6, o_level_5, o_level_4, o_level_3,
                         o_level_2, o_level_1, o_level_0};

    triangle_lfo_bank_ratio #(
        .NUM_CHANNELS(NUM_CHANNELS_DEF)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rate_cv   (i_rate_cv),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_level_0   (o_level_0),
        .o_level_1   (o_level_1),
        .o_level_2   (o_level_2),
        .o_level_3   (o_level_3),
        .o_level_4   (o_level_4),
        .o_level_5   (o_level_5),
        .o_level_6   (o_level_6)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            bank_track.note_rate_word(i_rate_cv);
        if (i_rst_n && o_out_valid && !i_out_stall)
            bank_track.check_levels(out_levels);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // hold off once for a long stretch so the bank fills and stalls its input
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_style = t_rx_style'($urandom_range(0, 3));
        if (!hold_done && bank_track.checked >= 300) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (rx_style)
                RX_FREE:  i_out_stall <= 1'b0;
                RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:  i_out_stall <= (rx_cycle % 5 < 2);
            endcase
        end
    end

    function automatic logic [CFG_DATA_W-1:0] rand45();
        return CFG_DATA_W'({$urandom, $urandom});
    endfunction

    function automatic logic [MULT_W-1:0] rand_mult();
        case ($urandom_range(0, 5))
            0:       return MULT_W'(48);
            1:       return MULT_W'(21504);
            2:       return MULT_W'($urandom);
            default: return MULT_W'($urandom_range(48, 21504));
        endcase
    endfunction

    function automatic logic signed [CV_W-1:0] rand_cv();
        case ($urandom_range(0, 15))
            0:       return CV_W'(40960);
            1:       return CV_W'(-40960);
            2, 3:    return CV_W'($urandom);
            default: return CV_W'($urandom_range(0, 81920) - 40960);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        bank_track.set_register(idx, data);
    endtask

    task automatic program_bank(input logic [CFG_DATA_W-1:0] base, gain, scale, bip,
                                input logic [CFG_DATA_W-1:0] first3, next3, last);
        write_reg(REG_BASE_RATE, base);
        write_reg(REG_CV_GAIN, gain);
        write_reg(REG_STEP_SCALE, scale);
        write_reg(REG_BIPOLAR, bip);
        write_reg(REG_MULTS_FIRST, first3);
        write_reg(REG_MULTS_NEXT, next3);
        write_reg(REG_MULT_LAST, last);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    task automatic send_word(input logic signed [CV_W-1:0] cv);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_rate_cv  <= cv;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (bank_track.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] r_base, r_gain, r_scale, r_bip, r_first, r_next, r_last;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(CV_W'(0));
        send_word(CV_W'(40960));
        send_word(CV_W'(-40960));
        send_word(CV_W'(65535));
        send_word(CV_W'(-65536));
        drain();

        // oversized registers: rates clamp, large steps saturate at one unit
        program_bank(CFG_DATA_W'(23'h7F_FFFF), CFG_DATA_W'(32767), CFG_DATA_W'({SCALE_W{1'b1}}),
                     CFG_DATA_W'(1), {CFG_DATA_W{1'b1}},
                     CFG_DATA_W'({15'd21504, 15'd48, 15'd21504}), CFG_DATA_W'(21504));
        send_word(CV_W'(0));
        send_word(CV_W'(40960));
        send_word(CV_W'(-40960));
        send_word(CV_W'(65535));
        send_word(CV_W'(-65536));
        send_word(CV_W'(1));
        send_word(CV_W'(-1));
        repeat (3) send_word(CV_W'(0));
        drain();

        program_bank(CFG_DATA_W'(655), CFG_DATA_W'(16'h8000), CFG_DATA_W'(1), CFG_DATA_W'(0),
                     CFG_DATA_W'(0), CFG_DATA_W'({3{15'd48}}), CFG_DATA_W'(48));
        send_word(CV_W'(40960));
        send_word(CV_W'(-40960));
        send_word(CV_W'(0));
        send_word(CV_W'(65535));
        send_word(CV_W'(-65536));
        send_word(CV_W'(2));
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       r_base = CFG_DATA_W'(655);
                1:       r_base = CFG_DATA_W'(6553600);
                2:       r_base = rand45();
                default: r_base = CFG_DATA_W'($urandom_range(655, 6553600));
            endcase
            case ($urandom_range(0, 5))
                0:       r_gain = CFG_DATA_W'(16'h8000);
                1:       r_gain = CFG_DATA_W'(32767);
                2:       r_gain = rand45();
                default: r_gain = CFG_DATA_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 5))
                0:       r_scale = CFG_DATA_W'(1);
                1:       r_scale = CFG_DATA_W'(64'd70368744177);
                2:       r_scale = rand45();
                default: r_scale = CFG_DATA_W'(64'({$urandom, $urandom}) % 64'd70368744177 + 1);
            endcase
            r_bip   = ($urandom_range(0, 3) == 0) ? rand45() : CFG_DATA_W'($urandom_range(0, 1));
            r_first = ($urandom_range(0, 5) == 0) ? rand45() :
                      CFG_DATA_W'({rand_mult(), rand_mult(), rand_mult()});
            r_next  = ($urandom_range(0, 5) == 0) ? rand45() :
                      CFG_DATA_W'({rand_mult(), rand_mult(), rand_mult()});
            r_last  = ($urandom_range(0, 5) == 0) ? rand45() : CFG_DATA_W'(rand_mult());
            program_bank(r_base, r_gain, r_scale, r_bip, r_first, r_next, r_last);
            repeat (PHASE_WORDS) send_word(rand_cv());
            drain();
        end

        $display("Covered %0d rate words over %0d bank settings, %0d results compared.",
                 bank_track.words, settings_used + 1, bank_track.checked);
        $display("Saturated steps %0d, top folds %0d, bottom folds %0d, clamped rates %0d.",
                 bank_track.saturated, bank_track.top_folds, bank_track.bottom_folds,
                 bank_track.clamped);
        if (bank_track.mismatches == 0 && bank_track.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
